/* hdl/assert_macros.svh */
// Assertion macros shared by the list engine modules.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("list engine check failed");
`define CLE_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("list engine check failed");
`else
`define CLE_ASSERT(lbl, clk, rstn, prop)
`define CLE_ASSERT_IMP(lbl, clk, rstn, pre, post)
`endif
`endif

/* hdl/cle_pkg.sv */
// Shared opcodes, defaults and controller/datapath handshake types.
// No dependencies.
`default_nettype none
package cle_pkg;
  localparam int CLE_POOL_NODES = 256;
  localparam int CLE_DATA_BITS  = 32;

  localparam logic [3:0] OP_INS_FIRST  = 4'd0;
  localparam logic [3:0] OP_INS_LAST   = 4'd1;
  localparam logic [3:0] OP_INS_AFTER  = 4'd2;
  localparam logic [3:0] OP_INS_BEFORE = 4'd3;
  localparam logic [3:0] OP_DEL_FIRST  = 4'd4;
  localparam logic [3:0] OP_DEL_LAST   = 4'd5;
  localparam logic [3:0] OP_DEL_AFTER  = 4'd6;
  localparam logic [3:0] OP_DEL_BEFORE = 4'd7;
  localparam logic [3:0] OP_FIRST      = 4'd8;
  localparam logic [3:0] OP_LAST       = 4'd9;
  localparam logic [3:0] OP_NEXT       = 4'd10;
  localparam logic [3:0] OP_PREV       = 4'd11;
  localparam logic [3:0] OP_SET_VALUE  = 4'd12;
  localparam logic [3:0] OP_CLEAR      = 4'd13;

  typedef struct packed {
    logic take;
    logic alloc_fresh;
    logic alloc_pop;
    logic alloc_cap;
    logic mark_full;
    logic rd_a;
    logic cap_a;
    logic rd_b;
    logic cap_b;
    logic wr1;
    logic wr2;
    logic rd_head;
    logic rd_tail;
    logic rd_cur;
    logic load;
  } cle_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       cur_nil;
    logic       head_nil;
    logic       tail_nil;
    logic       fresh_avail;
    logic       stack_avail;
    logic       ptr_nil;
    logic       out_busy;
  } cle_stat_t;
endpackage
`default_nettype wire

/* hdl/cursor_linked_list_engine.sv */
// Doubly linked list engine with a cursor: top level.
// Depends on cle_pkg, cle_ctrl, cle_datapath (which uses cle_ram).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode_i and value_i. One
//   transfer is one list operation. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result per operation: list status, head, tail and
//   cursor values, node count and the pool-full flag.
// Sequencing:
//   One operation at a time. From its input transfer to its result in the
//   output register, the sequencer walks one read of the link memories per
//   step (up to two for the neighbor deletes), an extra step for a free-stack
//   pop, two link-write phases since each link memory has a single write port,
//   and three reads of the data memory to fetch head, tail and cursor values
//   through its one read port. Refused operations skip link reads and writes.
//   A new operation is taken in the cycle after the previous one has loaded
//   its result, so input transfers overlap a result waiting in the output reg.
// Reset:
//   Empty list, inactive cursor, empty allocator; no memory clearing pass,
//   so the block accepts an operation as soon as reset is released.
// Stall:
//   If the receiver holds out_ready_i low, the result stays valid and stable;
//   the next operation runs but waits before its own result is loaded.
`default_nettype none
module cursor_linked_list_engine import cle_pkg::*; #(
  parameter int POOL_NODES = CLE_POOL_NODES,
  parameter int DATA_BITS  = CLE_DATA_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [3:0]  opcode_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    list_empty_o,
  output logic                    cursor_active_o,
  output logic signed      [31:0] first_value_o,
  output logic signed      [31:0] last_value_o,
  output logic signed      [31:0] cursor_value_o,
  output logic             [8:0]  element_count_o,
  output logic                    pool_full_error_o
);
  cle_cmd_t  cmd;
  cle_stat_t stat;

  // sequencer: steps one operation through alloc, read, write and fetch
  cle_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd));

  // node memories, pointers and result register
  cle_datapath #(.POOL_NODES(POOL_NODES), .DATA_BITS(DATA_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .opcode_i, .value_i, .out_ready_i, .out_valid_o,
    .list_empty_o, .cursor_active_o, .first_value_o, .last_value_o,
    .cursor_value_o, .element_count_o, .pool_full_error_o);
endmodule
`default_nettype wire

/* hdl/cle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* hdl/cle_ctrl.sv */
// Sequencing state machine of the list engine.
// Depends on cle_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cle_ctrl import cle_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cle_stat_t stat_i,
  output cle_cmd_t       cmd_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_ALLOCW = 4'd2;
  localparam logic [3:0] S_RA     = 4'd3;
  localparam logic [3:0] S_RAW    = 4'd4;
  localparam logic [3:0] S_RB     = 4'd5;
  localparam logic [3:0] S_RBW    = 4'd6;
  localparam logic [3:0] S_WR1    = 4'd7;
  localparam logic [3:0] S_WR2    = 4'd8;
  localparam logic [3:0] S_QH     = 4'd9;
  localparam logic [3:0] S_QT     = 4'd10;
  localparam logic [3:0] S_QC     = 4'd11;
  localparam logic [3:0] S_LOAD   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       need_cur, skip, is_alloc, need_ra, two_reads;

  always_comb begin
    need_cur = (stat_i.op == OP_INS_AFTER) || (stat_i.op == OP_INS_BEFORE) ||
               (stat_i.op == OP_DEL_AFTER) || (stat_i.op == OP_DEL_BEFORE) ||
               (stat_i.op == OP_NEXT) || (stat_i.op == OP_PREV) ||
               (stat_i.op == OP_SET_VALUE);
    skip = (need_cur && stat_i.cur_nil) ||
           ((stat_i.op == OP_DEL_FIRST) && stat_i.head_nil) ||
           ((stat_i.op == OP_DEL_LAST) && stat_i.tail_nil);
    is_alloc = (stat_i.op == OP_INS_FIRST) || (stat_i.op == OP_INS_LAST) ||
               (stat_i.op == OP_INS_AFTER) || (stat_i.op == OP_INS_BEFORE);
    two_reads = (stat_i.op == OP_DEL_AFTER) || (stat_i.op == OP_DEL_BEFORE);
    need_ra = (stat_i.op == OP_INS_AFTER) || (stat_i.op == OP_INS_BEFORE) ||
              (stat_i.op == OP_DEL_FIRST) || (stat_i.op == OP_DEL_LAST) ||
              two_reads || (stat_i.op == OP_NEXT) || (stat_i.op == OP_PREV);
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (skip) begin
          state_d = S_QH;
        end else if (is_alloc) begin
          if (stat_i.fresh_avail) begin
            cmd_o.alloc_fresh = 1'b1;
            state_d = need_ra ? S_RA : S_WR1;
          end else if (stat_i.stack_avail) begin
            cmd_o.alloc_pop = 1'b1;
            state_d = S_ALLOCW;
          end else begin
            cmd_o.mark_full = 1'b1;
            state_d = S_QH;
          end
        end else begin
          state_d = need_ra ? S_RA : S_WR1;
        end
      end
      S_ALLOCW: begin
        cmd_o.alloc_cap = 1'b1;
        state_d = need_ra ? S_RA : S_WR1;
      end
      S_RA: begin
        cmd_o.rd_a = 1'b1;
        state_d = S_RAW;
      end
      S_RAW: begin
        cmd_o.cap_a = 1'b1;
        if (two_reads) begin
          state_d = stat_i.ptr_nil ? S_QH : S_RB;
        end else begin
          state_d = S_WR1;
        end
      end
      S_RB: begin
        cmd_o.rd_b = 1'b1;
        state_d = S_RBW;
      end
      S_RBW: begin
        cmd_o.cap_b = 1'b1;
        state_d = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d = S_QH;
      end
      S_QH: begin
        cmd_o.rd_head = 1'b1;
        state_d = S_QT;
      end
      S_QT: begin
        cmd_o.rd_tail = 1'b1;
        state_d = S_QC;
      end
      S_QC: begin
        cmd_o.rd_cur = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (!stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CLE_ASSERT(a_take_starts, clk_i, rst_ni, cmd_o.take |=> (state_q == S_START))
  `CLE_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_o.load, !stat_i.out_busy)
  `CLE_ASSERT_IMP(a_full_empty, clk_i, rst_ni, cmd_o.mark_full, !stat_i.fresh_avail)
endmodule
`default_nettype wire

/* hdl/cle_datapath.sv */
// Node pool memories, list pointers, allocator and result register.
// Depends on cle_pkg, cle_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cle_datapath import cle_pkg::*; #(
  parameter int POOL_NODES = CLE_POOL_NODES,
  parameter int DATA_BITS  = CLE_DATA_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cle_cmd_t           cmd_i,
  output cle_stat_t               stat_o,
  input  wire logic        [3:0]  opcode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic                    list_empty_o,
  output logic                    cursor_active_o,
  output logic signed      [31:0] first_value_o,
  output logic signed      [31:0] last_value_o,
  output logic signed      [31:0] cursor_value_o,
  output logic             [8:0]  element_count_o,
  output logic                    pool_full_error_o
);
  localparam int AW = $clog2(POOL_NODES);
  localparam int IW = $clog2(POOL_NODES + 1);
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);
  localparam int CW = (DATA_BITS < 32) ? DATA_BITS : 32;

  function automatic logic [31:0] fmt(input logic [DATA_BITS-1:0] x);
    logic [31:0] r;
    r = '0;
    r[CW-1:0] = x[CW-1:0];
    return r;
  endfunction

  // list control state
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [IW-1:0] fresh_q, fresh_d, ftop_q, ftop_d, live_q, live_d;
  logic          out_valid_q, out_valid_d;
  // per-operation scratch and result payload
  logic [3:0]           op_q, op_d;
  logic [DATA_BITS-1:0] val_q, val_d, hv_q, hv_d, tv_q, tv_d;
  logic [IW-1:0]        n_q, n_d, a_q, a_d, b_q, b_d;
  logic                 full_q, full_d;
  logic                 empty_q, act_q, err_q;
  logic [31:0]          first_q, last_q, curv_q;
  logic [8:0]           count_q;
  logic [DATA_BITS-1:0] vin;

  // memory ports
  logic                 fwd_we, bwd_we, dat_we, fs_we;
  logic [AW-1:0]        fwd_wa, bwd_wa, dat_wa, fs_wa;
  logic [IW-1:0]        fwd_wd, bwd_wd, fwd_rd, bwd_rd, ptr_rd;
  logic [DATA_BITS-1:0] dat_wd, dat_rd;
  logic [AW-1:0]        fs_wd, fs_rd, ptr_ra, dat_ra, fs_ra;
  logic                 ptr_re, dat_re;
  logic                 push;
  logic [IW-1:0]        push_node;

  always_comb begin
    vin = '0;
    vin[CW-1:0] = value_i[CW-1:0];
  end

  assign ptr_rd = op_q[0] ? bwd_rd : fwd_rd;

  cle_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_wa), .wdata_i(fwd_wd),
    .re_i(ptr_re), .raddr_i(ptr_ra), .rdata_o(fwd_rd));
  cle_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_bwd (
    .clk_i, .we_i(bwd_we), .waddr_i(bwd_wa), .wdata_i(bwd_wd),
    .re_i(ptr_re), .raddr_i(ptr_ra), .rdata_o(bwd_rd));
  cle_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_NODES)) u_data (
    .clk_i, .we_i(dat_we), .waddr_i(dat_wa), .wdata_i(dat_wd),
    .re_i(dat_re), .raddr_i(dat_ra), .rdata_o(dat_rd));
  cle_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_fstack (
    .clk_i, .we_i(fs_we), .waddr_i(fs_wa), .wdata_i(fs_wd),
    .re_i(cmd_i.alloc_pop), .raddr_i(fs_ra), .rdata_o(fs_rd));

  // read addresses
  always_comb begin
    if (cmd_i.rd_b) begin
      ptr_ra = a_q[AW-1:0];
    end else if (op_q == OP_DEL_FIRST) begin
      ptr_ra = head_q[AW-1:0];
    end else if (op_q == OP_DEL_LAST) begin
      ptr_ra = tail_q[AW-1:0];
    end else begin
      ptr_ra = cur_q[AW-1:0];
    end
    ptr_re = cmd_i.rd_a | cmd_i.rd_b;
    if (cmd_i.rd_head) begin
      dat_ra = head_q[AW-1:0];
    end else if (cmd_i.rd_tail) begin
      dat_ra = tail_q[AW-1:0];
    end else begin
      dat_ra = cur_q[AW-1:0];
    end
    dat_re = cmd_i.rd_head | cmd_i.rd_tail | cmd_i.rd_cur;
    fs_ra  = AW'(ftop_q - 1'b1);
  end

  // link writes, two phases so each memory sees one write per cycle
  always_comb begin
    fwd_we = 1'b0; fwd_wa = '0; fwd_wd = '0;
    bwd_we = 1'b0; bwd_wa = '0; bwd_wd = '0;
    dat_we = 1'b0; dat_wa = n_q[AW-1:0]; dat_wd = val_q;
    push = 1'b0; push_node = head_q;
    if (cmd_i.wr1) begin
      case (op_q)
        OP_INS_FIRST: begin
          dat_we = 1'b1;
          fwd_we = 1'b1; fwd_wa = n_q[AW-1:0]; fwd_wd = head_q;
          bwd_we = 1'b1; bwd_wa = n_q[AW-1:0]; bwd_wd = NIL;
        end
        OP_INS_LAST: begin
          dat_we = 1'b1;
          bwd_we = 1'b1; bwd_wa = n_q[AW-1:0]; bwd_wd = tail_q;
          fwd_we = 1'b1; fwd_wa = n_q[AW-1:0]; fwd_wd = NIL;
        end
        OP_INS_AFTER: begin
          dat_we = 1'b1;
          fwd_we = 1'b1; fwd_wa = cur_q[AW-1:0]; fwd_wd = n_q;
          bwd_we = 1'b1; bwd_wa = n_q[AW-1:0]; bwd_wd = cur_q;
        end
        OP_INS_BEFORE: begin
          dat_we = 1'b1;
          bwd_we = 1'b1; bwd_wa = cur_q[AW-1:0]; bwd_wd = n_q;
          fwd_we = 1'b1; fwd_wa = n_q[AW-1:0]; fwd_wd = cur_q;
        end
        OP_DEL_FIRST: begin
          bwd_we = (a_q != NIL); bwd_wa = a_q[AW-1:0]; bwd_wd = NIL;
          push = 1'b1; push_node = head_q;
        end
        OP_DEL_LAST: begin
          fwd_we = (a_q != NIL); fwd_wa = a_q[AW-1:0]; fwd_wd = NIL;
          push = 1'b1; push_node = tail_q;
        end
        OP_DEL_AFTER: begin
          bwd_we = (b_q != NIL); bwd_wa = b_q[AW-1:0]; bwd_wd = cur_q;
          fwd_we = 1'b1; fwd_wa = cur_q[AW-1:0]; fwd_wd = b_q;
          push = 1'b1; push_node = a_q;
        end
        OP_DEL_BEFORE: begin
          fwd_we = (b_q != NIL); fwd_wa = b_q[AW-1:0]; fwd_wd = cur_q;
          bwd_we = 1'b1; bwd_wa = cur_q[AW-1:0]; bwd_wd = b_q;
          push = 1'b1; push_node = a_q;
        end
        OP_SET_VALUE: begin
          dat_we = 1'b1; dat_wa = cur_q[AW-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd_i.wr2) begin
      case (op_q)
        OP_INS_FIRST: begin
          bwd_we = (head_q != NIL); bwd_wa = head_q[AW-1:0]; bwd_wd = n_q;
        end
        OP_INS_LAST: begin
          fwd_we = (tail_q != NIL); fwd_wa = tail_q[AW-1:0]; fwd_wd = n_q;
        end
        OP_INS_AFTER: begin
          fwd_we = 1'b1; fwd_wa = n_q[AW-1:0]; fwd_wd = a_q;
          bwd_we = (a_q != NIL); bwd_wa = a_q[AW-1:0]; bwd_wd = n_q;
        end
        OP_INS_BEFORE: begin
          bwd_we = 1'b1; bwd_wa = n_q[AW-1:0]; bwd_wd = a_q;
          fwd_we = (a_q != NIL); fwd_wa = a_q[AW-1:0]; fwd_wd = n_q;
        end
        default: begin
        end
      endcase
    end
    fs_we = push && (ftop_q < NIL);
    fs_wa = ftop_q[AW-1:0];
    fs_wd = push_node[AW-1:0];
  end

  // register next values
  always_comb begin
    head_d = head_q; tail_d = tail_q; cur_d = cur_q;
    fresh_d = fresh_q; ftop_d = ftop_q; live_d = live_q;
    op_d = op_q; val_d = val_q; n_d = n_q; a_d = a_q; b_d = b_q;
    full_d = full_q; hv_d = hv_q; tv_d = tv_q;
    if (cmd_i.take) begin
      op_d = opcode_i; val_d = vin; full_d = 1'b0;
    end
    if (cmd_i.alloc_fresh) begin
      n_d = fresh_q; fresh_d = fresh_q + 1'b1; live_d = live_q + 1'b1;
    end
    if (cmd_i.alloc_pop) begin
      ftop_d = ftop_q - 1'b1; live_d = live_q + 1'b1;
    end
    if (cmd_i.alloc_cap) n_d = IW'(fs_rd);
    if (cmd_i.mark_full) full_d = 1'b1;
    if (cmd_i.cap_a) a_d = ptr_rd;
    if (cmd_i.cap_b) b_d = ptr_rd;
    if (push) begin
      if (ftop_q < NIL) ftop_d = ftop_q + 1'b1;
      if (live_q != '0) live_d = live_q - 1'b1;
    end
    if (cmd_i.wr2) begin
      case (op_q)
        OP_INS_FIRST: begin
          if (head_q == NIL) tail_d = n_q;
          head_d = n_q;
        end
        OP_INS_LAST: begin
          if (tail_q == NIL) head_d = n_q;
          tail_d = n_q;
        end
        OP_INS_AFTER:  if (a_q == NIL) tail_d = n_q;
        OP_INS_BEFORE: if (a_q == NIL) head_d = n_q;
        OP_DEL_FIRST: begin
          if (cur_q == head_q) cur_d = NIL;
          head_d = a_q;
          if (a_q == NIL) tail_d = NIL;
        end
        OP_DEL_LAST: begin
          if (cur_q == tail_q) cur_d = NIL;
          tail_d = a_q;
          if (a_q == NIL) head_d = NIL;
        end
        OP_DEL_AFTER:  if (b_q == NIL) tail_d = cur_q;
        OP_DEL_BEFORE: if (b_q == NIL) head_d = cur_q;
        OP_FIRST: cur_d = head_q;
        OP_LAST:  cur_d = tail_q;
        OP_NEXT, OP_PREV: cur_d = a_q;
        OP_CLEAR: begin
          head_d = NIL; tail_d = NIL; cur_d = NIL;
          fresh_d = '0; ftop_d = '0; live_d = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.rd_tail) hv_d = dat_rd;
    if (cmd_i.rd_cur) tv_d = dat_rd;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NIL; tail_q <= NIL; cur_q <= NIL;
      fresh_q <= '0; ftop_q <= '0; live_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d;
      fresh_q <= fresh_d; ftop_q <= ftop_d; live_q <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; val_q <= val_d; n_q <= n_d; a_q <= a_d; b_q <= b_d;
    full_q <= full_d; hv_q <= hv_d; tv_q <= tv_d;
    if (cmd_i.load) begin
      empty_q <= (head_q == NIL);
      act_q   <= (cur_q != NIL);
      first_q <= (head_q == NIL) ? '0 : fmt(hv_q);
      last_q  <= (tail_q == NIL) ? '0 : fmt(tv_q);
      curv_q  <= (cur_q == NIL) ? '0 : fmt(dat_rd);
      count_q <= 9'(live_q);
      err_q   <= full_q;
    end
  end

  always_comb begin
    stat_o.op          = op_q;
    stat_o.cur_nil     = (cur_q == NIL);
    stat_o.head_nil    = (head_q == NIL);
    stat_o.tail_nil    = (tail_q == NIL);
    stat_o.fresh_avail = (fresh_q < NIL);
    stat_o.stack_avail = (ftop_q != '0);
    stat_o.ptr_nil     = (ptr_rd == NIL);
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign list_empty_o      = empty_q;
  assign cursor_active_o   = act_q;
  assign first_value_o     = first_q;
  assign last_value_o      = last_q;
  assign cursor_value_o    = curv_q;
  assign element_count_o   = count_q;
  assign pool_full_error_o = err_q;

  `CLE_ASSERT(a_pool_balance, clk_i, rst_ni, ((IW+1)'(live_q) + (IW+1)'(ftop_q)) == (IW+1)'(fresh_q))
  `CLE_ASSERT(a_ends_agree, clk_i, rst_ni, (head_q == NIL) == (tail_q == NIL))
  `CLE_ASSERT(a_live_bound, clk_i, rst_ni, live_q <= NIL)
endmodule
`default_nettype wire

/* bench/cursor_linked_list_engine_test.sv */
// Self-checking bench for the cursor linked list engine.
// Depends on cle_pkg and the cursor_linked_list_engine RTL; drives list ops, checks results.
`default_nettype none
module cursor_linked_list_engine_test;
  import cle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = CLE_POOL_NODES;
  localparam int NULL_IDX = NODES;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] opcode_i = OP_FIRST;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic list_empty_o, cursor_active_o, pool_full_error_o;
  logic signed [31:0] first_value_o, last_value_o, cursor_value_o;
  logic [8:0] element_count_o;

  always #6 clk_i = ~clk_i;

  cursor_linked_list_engine uut (.*);

  // One list status snapshot, as the block reports it after each transfer.
  typedef struct packed {
    logic empty;
    logic active;
    logic signed [31:0] head_val;
    logic signed [31:0] tail_val;
    logic signed [31:0] cur_val;
    logic [8:0] count;
    logic full;
  } status_t;

  // Directed row: op, value, and an optional typed-in expectation.
  typedef struct {
    logic [3:0] op;
    logic signed [31:0] val;
    bit has_exp;
    status_t exp;
  } row_t;

  // Shadow copy of the node pool.
  logic signed [31:0] sh_data [NODES];
  int sh_fwd [NODES];
  int sh_bwd [NODES];
  int sh_free [NODES];
  int sh_head = NULL_IDX, sh_tail = NULL_IDX, sh_cur = NULL_IDX;
  int sh_fresh = 0, sh_top = 0, sh_live = 0;

  status_t pending_status [$];
  int errors = 0;
  bit quiet = 1'b0;   // last part of the run: no idling on either side

  function automatic int grab_node();
    if (sh_fresh < NODES) begin
      sh_fresh++; sh_live++;
      return sh_fresh - 1;
    end
    if (sh_top > 0) begin
      sh_top--; sh_live++;
      return sh_free[sh_top];
    end
    return NULL_IDX;
  endfunction

  function automatic void drop_node(int n);
    if (sh_top < NODES && n < NULL_IDX) begin
      sh_free[sh_top] = n;
      sh_top++;
    end
    if (sh_live > 0) sh_live--;
  endfunction

  // Apply one operation to the shadow list and return the status it leaves.
  function automatic status_t apply_list_op(logic [3:0] op, logic signed [31:0] v);
    int c, n, nb, d;
    status_t s;
    bit full;
    c = sh_cur;
    full = 1'b0;
    case (op)
      OP_INS_FIRST, OP_INS_LAST: begin
        n = grab_node();
        if (n == NULL_IDX) full = 1'b1;
        else begin
          sh_data[n] = v;
          if (op == OP_INS_FIRST) begin
            sh_fwd[n] = sh_head; sh_bwd[n] = NULL_IDX;
            if (sh_head == NULL_IDX) sh_tail = n;
            else sh_bwd[sh_head] = n;
            sh_head = n;
          end else begin
            sh_bwd[n] = sh_tail; sh_fwd[n] = NULL_IDX;
            if (sh_tail == NULL_IDX) sh_head = n;
            else sh_fwd[sh_tail] = n;
            sh_tail = n;
          end
        end
      end
      OP_INS_AFTER: if (c != NULL_IDX) begin
        n = grab_node();
        if (n == NULL_IDX) full = 1'b1;
        else begin
          nb = sh_fwd[c];
          if (nb == NULL_IDX) sh_tail = n; else sh_bwd[nb] = n;
          sh_fwd[c] = n; sh_bwd[n] = c; sh_fwd[n] = nb; sh_data[n] = v;
        end
      end
      OP_INS_BEFORE: if (c != NULL_IDX) begin
        n = grab_node();
        if (n == NULL_IDX) full = 1'b1;
        else begin
          nb = sh_bwd[c];
          if (nb == NULL_IDX) sh_head = n; else sh_fwd[nb] = n;
          sh_bwd[c] = n; sh_fwd[n] = c; sh_bwd[n] = nb; sh_data[n] = v;
        end
      end
      OP_DEL_FIRST: if (sh_head != NULL_IDX) begin
        d = sh_head; nb = sh_fwd[d];
        if (c == d) sh_cur = NULL_IDX;
        sh_head = nb;
        if (nb == NULL_IDX) sh_tail = NULL_IDX; else sh_bwd[nb] = NULL_IDX;
        drop_node(d);
      end
      OP_DEL_LAST: if (sh_tail != NULL_IDX) begin
        d = sh_tail; nb = sh_bwd[d];
        if (c == d) sh_cur = NULL_IDX;
        sh_tail = nb;
        if (nb == NULL_IDX) sh_head = NULL_IDX; else sh_fwd[nb] = NULL_IDX;
        drop_node(d);
      end
      OP_DEL_AFTER: if (c != NULL_IDX && sh_fwd[c] != NULL_IDX) begin
        d = sh_fwd[c]; nb = sh_fwd[d];
        if (nb == NULL_IDX) sh_tail = c; else sh_bwd[nb] = c;
        sh_fwd[c] = nb;
        drop_node(d);
      end
      OP_DEL_BEFORE: if (c != NULL_IDX && sh_bwd[c] != NULL_IDX) begin
        d = sh_bwd[c]; nb = sh_bwd[d];
        if (nb == NULL_IDX) sh_head = c; else sh_fwd[nb] = c;
        sh_bwd[c] = nb;
        drop_node(d);
      end
      OP_FIRST: sh_cur = sh_head;
      OP_LAST: sh_cur = sh_tail;
      OP_NEXT: if (c != NULL_IDX) sh_cur = sh_fwd[c];
      OP_PREV: if (c != NULL_IDX) sh_cur = sh_bwd[c];
      OP_SET_VALUE: if (c != NULL_IDX) sh_data[c] = v;
      OP_CLEAR: begin
        sh_head = NULL_IDX; sh_tail = NULL_IDX; sh_cur = NULL_IDX;
        sh_fresh = 0; sh_top = 0; sh_live = 0;
      end
      default: ;
    endcase
    s.empty = (sh_head == NULL_IDX);
    s.active = (sh_cur != NULL_IDX);
    s.head_val = (sh_head == NULL_IDX) ? '0 : sh_data[sh_head];
    s.tail_val = (sh_tail == NULL_IDX) ? '0 : sh_data[sh_tail];
    s.cur_val = (sh_cur == NULL_IDX) ? '0 : sh_data[sh_cur];
    s.count = sh_live[8:0];
    s.full = full;
    return s;
  endfunction

  // Present one operation at the falling edge and wait for its transfer.
  // Ready is read at the falling edge, where it holds its value for the next rise.
  task automatic send_op(logic [3:0] op, logic signed [31:0] v, bit has_exp, status_t exp);
    status_t s;
    bit rdy;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    value_i <= v;
    rdy = in_ready_o;
    @(posedge clk_i);
    while (!rdy) begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end
    s = apply_list_op(op, v);
    if (has_exp && s != exp) begin
      $error("directed row disagrees with predictor for op %0d", op);
      errors++;
    end
    pending_status.push_back(s);
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, compare each transfer with the oldest expectation.
  // Outputs are captured at the falling edge, where they hold for the next rise.
  initial begin
    status_t e;
    status_t got;
    bit hit;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      hit = rst_ni && out_valid_o;
      got.empty = list_empty_o;
      got.active = cursor_active_o;
      got.head_val = first_value_o;
      got.tail_val = last_value_o;
      got.cur_val = cursor_value_o;
      got.count = element_count_o;
      got.full = pool_full_error_o;
      @(posedge clk_i);
      if (hit) begin
        if (pending_status.size() == 0) begin
          $error("result with no pending operation");
          errors++;
        end else begin
          e = pending_status.pop_front();
          if (got.empty !== e.empty) begin
            $error("list_empty exp %0d got %0d", e.empty, got.empty); errors++;
          end
          if (got.active !== e.active) begin
            $error("cursor_active exp %0d got %0d", e.active, got.active); errors++;
          end
          if (got.head_val !== e.head_val) begin
            $error("first_value exp %0d got %0d", e.head_val, got.head_val); errors++;
          end
          if (got.tail_val !== e.tail_val) begin
            $error("last_value exp %0d got %0d", e.tail_val, got.tail_val); errors++;
          end
          if (got.cur_val !== e.cur_val) begin
            $error("cursor_value exp %0d got %0d", e.cur_val, got.cur_val); errors++;
          end
          if (got.count !== e.count) begin
            $error("element_count exp %0d got %0d", e.count, got.count); errors++;
          end
          if (got.full !== e.full) begin
            $error("pool_full_error exp %0d got %0d", e.full, got.full); errors++;
          end
        end
      end
    end
  end

  function automatic status_t mk(int em, int ac, int hv, int tv, int cv, int cnt, int fl);
    status_t s;
    s.empty = em[0]; s.active = ac[0]; s.head_val = hv; s.tail_val = tv;
    s.cur_val = cv; s.count = cnt[8:0]; s.full = fl[0];
    return s;
  endfunction

  // Random value, extremes now and then so every bit sees both levels.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'shffffffff;
      3: return 32'sh0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t rows [$];
    status_t none;
    int k;
    logic [3:0] op;
    none = '0;
    // Directed part: empty-list no-ops first, then extremes and each special case.
    rows = '{
      '{OP_DEL_FIRST,  0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_DEL_LAST,   0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_FIRST,      0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_LAST,       0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_NEXT,       0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_PREV,       0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_SET_VALUE,  5, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_INS_AFTER,  5, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_INS_BEFORE, 5, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_DEL_AFTER,  0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_DEL_BEFORE, 0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)},
      '{OP_INS_LAST,  32'sh7fffffff, 1'b1,
        mk(0, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 1, 0)},
      '{OP_INS_FIRST, 32'sh80000000, 1'b1,
        mk(0, 0, 32'sh80000000, 32'sh7fffffff, 0, 2, 0)},
      '{OP_LAST,       0, 1'b0, none},
      '{OP_INS_BEFORE, -1, 1'b0, none},
      '{OP_PREV,       0, 1'b0, none},
      '{OP_DEL_BEFORE, 0, 1'b0, none},
      '{OP_INS_AFTER,  32'sh55aa55aa, 1'b0, none},
      '{OP_NEXT,       0, 1'b0, none},
      '{OP_DEL_AFTER,  0, 1'b0, none},
      '{OP_SET_VALUE,  32'sh0f0f0f0f, 1'b0, none},
      '{OP_DEL_FIRST,  0, 1'b0, none},
      '{4'd14,         0, 1'b0, none},
      '{4'd15,         -1, 1'b0, none},
      '{OP_CLEAR,      0, 1'b1, mk(1, 0, 0, 0, 0, 0, 0)}
    };
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_op(rows[i].op, rows[i].val, rows[i].has_exp, rows[i].exp);

    // Fill the pool to capacity, move the cursor to the head, then push each insert against it.
    for (k = 0; k < NODES; k++) begin
      send_op(k[0] ? OP_INS_LAST : OP_INS_FIRST, pick_value(), 1'b0, none);
    end
    send_op(OP_FIRST, 0, 1'b0, none);
    for (k = 0; k < 4; k++) send_op(OP_INS_FIRST + k[1:0], pick_value(), 1'b0, none);

    // Hold the sender until every result is back.
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);

    // Random part: biased toward inserts and cursor moves so the list grows.
    for (k = 0; k < 360; k++) begin
      if (k >= 300) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_INS_FIRST + 4'($urandom_range(0, 3));
        3, 4:    op = OP_INS_LAST;
        5, 6, 7: op = OP_DEL_FIRST + 4'($urandom_range(0, 3));
        8, 9, 10, 11: op = OP_FIRST + 4'($urandom_range(0, 3));
        12, 13:  op = OP_SET_VALUE;
        14:      op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_NEXT;
        15:      op = 4'($urandom_range(14, 15));
        default: op = 4'($urandom_range(0, 3));
      endcase
      send_op(op, pick_value(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("PASS cursor_linked_list_engine");
    else $display("FAIL cursor_linked_list_engine");
    $finish;
  end

  initial begin
    #3ms;
    $display("FAIL cursor_linked_list_engine");
    $finish;
  end
endmodule
`default_nettype wire
